// ===== src/iirdf2_pkg.sv =====
// Package for the Direct Form II IIR filter: default parameter values,
// register and command codes, coefficient slot order, sequencer states and control struct.
// Has no dependencies; every other file of the filter imports it.
package iirdf2_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_WIDTH_DEF   = 32;
	localparam int MAX_ORDER_DEF    = 4;

	// State words and coefficient slots are always 32 bits wide.
	localparam int STATE_W = 32;
	localparam int SLOT_W  = 32;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_ORDER_FOUR = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_B0_B1      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_B2_B3      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_B4_A1      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_A2_A3      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_A4         = 3'd5;

	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Coefficient slot order: feedforward taps first, then feedback taps.
	localparam int NUM_COEF   = 9;
	localparam int COEF_IDX_W = 4;
	localparam logic [COEF_IDX_W-1:0] COEF_B0 = 4'd0;
	localparam logic [COEF_IDX_W-1:0] COEF_B1 = 4'd1;
	localparam logic [COEF_IDX_W-1:0] COEF_B2 = 4'd2;
	localparam logic [COEF_IDX_W-1:0] COEF_B3 = 4'd3;
	localparam logic [COEF_IDX_W-1:0] COEF_B4 = 4'd4;
	localparam logic [COEF_IDX_W-1:0] COEF_A1 = 4'd5;
	localparam logic [COEF_IDX_W-1:0] COEF_A2 = 4'd6;
	localparam logic [COEF_IDX_W-1:0] COEF_A3 = 4'd7;
	localparam logic [COEF_IDX_W-1:0] COEF_A4 = 4'd8;

	// b0 comes out of reset as 1.0 in Q4.28.
	localparam logic [SLOT_W-1:0] B0_RESET = 32'h1000_0000;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b000_0001,
		ST_FBACK    = 7'b000_0010,
		ST_FB_DRAIN = 7'b000_0100,
		ST_FB_ROUND = 7'b000_1000,
		ST_FFWD     = 7'b001_0000,
		ST_FF_DRAIN = 7'b010_0000,
		ST_FF_ROUND = 7'b100_0000
	} seq_state_t;

	// Control from the sequencer to the shared multiply-accumulate unit.
	typedef struct packed {
		logic load_sample; // accumulator takes the input sample, scaled
		logic clear;       // accumulator goes to zero
		logic issue;       // a product is started this cycle
		logic subtract;    // that product is subtracted
		logic to_sample;   // round and clip to the sample range, not the state range
	} mac_ctrl_t;

endpackage

// ===== src/iirdf2_if.sv =====
// Valid/ready channel interfaces of the IIR filter: sample words in, filtered words out.
// Depends on iirdf2_pkg for the default sample width.
interface iirdf2_in_if
	import iirdf2_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output command, output sample_in, input ready);
	modport sink (input valid, input command, input sample_in, output ready);
endinterface

interface iirdf2_out_if
	import iirdf2_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

// ===== src/iirdf2_mac.sv =====
// Shared multiply-accumulate unit of the IIR filter, with rounding and saturation.
// Depends on iirdf2_pkg for the control struct and the state width.
module iirdf2_mac
	import iirdf2_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mac_ctrl_t                      ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [COEF_WIDTH-1:0]   coef,
	input  logic signed [STATE_W-1:0]      data,
	output logic signed [STATE_W-1:0]      result,
	output logic                           clip
);
	localparam int FRAC   = COEF_WIDTH - 4;
	localparam int PROD_W = COEF_WIDTH + STATE_W;
	// Four guard bits above the product width: room for sixteen full products.
	localparam int ACC_W  = COEF_WIDTH + STATE_W + 4;

	localparam logic signed [ACC_W-1:0] HALF_LSB   = ACC_W'(1) <<< (FRAC - 1);
	localparam logic signed [ACC_W-1:0] SAMPLE_MAX = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAMPLE_MIN = ~SAMPLE_MAX;
	localparam logic signed [ACC_W-1:0] STATE_MAX  = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] STATE_MIN  = ~STATE_MAX;

	logic signed [PROD_W-1:0] product_s1;
	logic                     valid_s1;
	logic                     sub_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded;
	logic signed [ACC_W-1:0]  hi_lim;
	logic signed [ACC_W-1:0]  lo_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			product_s1 <= PROD_W'(coef) * PROD_W'(data);
			sub_s1     <= ctrl.subtract;
		end
		if (ctrl.load_sample) begin
			acc_q <= ACC_W'(sample) <<< FRAC;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			if (sub_s1) begin
				acc_q <= acc_q - ACC_W'(product_s1);
			end else begin
				acc_q <= acc_q + ACC_W'(product_s1);
			end
		end
	end

	// Round half up, then clip to the selected range.
	always_comb begin
		rounded = (acc_q + HALF_LSB) >>> FRAC;
		hi_lim  = ctrl.to_sample ? SAMPLE_MAX : STATE_MAX;
		lo_lim  = ctrl.to_sample ? SAMPLE_MIN : STATE_MIN;
		if (rounded > hi_lim) begin
			result = hi_lim[STATE_W-1:0];
			clip   = 1'b1;
		end else if (rounded < lo_lim) begin
			result = lo_lim[STATE_W-1:0];
			clip   = 1'b1;
		end else begin
			result = rounded[STATE_W-1:0];
			clip   = 1'b0;
		end
	end

endmodule

// ===== src/iir_direct_form_two_filter.sv =====
// Top level of the Direct Form II IIR filter of order 2 or 4.
// Depends on iirdf2_pkg, the channel interfaces in iirdf2_if and the unit iirdf2_mac.
//
// Usage. Coefficients are written through cfg_write, cfg_index and cfg_data while the
// filter is idle: index 0 selects the order, 1 to 4 hold two Q4.28 coefficients each
// (low slot in bits 31:0), 5 holds a4. Words enter on the samples channel: command
// filter runs one sample, command clear zeroes the delay line and yields no word.
// Each filtered word leaves on the results channel with a flag that is set when the
// state or the output was clipped.
// Timing. All products go through one multiplier followed by one accumulator. A sample
// runs from acceptance to a valid result through n feedback products, n being the order,
// a pipeline drain step and a rounding step, then n+1 feedforward products, a drain step
// and a final rounding step. Ready returns together with the result, so the filter takes
// no new sample while it works on one. A clear command is handled in the idle state.
// Reset clears the delay line, selects second order, sets b0 to 1.0 and all other
// coefficients to zero. If the receiver stalls, the finished word waits in the output
// register; the filter takes and works on one more sample and then holds it at the
// final step until the waiting word is taken.
module iir_direct_form_two_filter
	import iirdf2_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
	parameter int MAX_ORDER    = MAX_ORDER_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	iirdf2_in_if.sink              samples,
	iirdf2_out_if.source           results
);
	localparam int TAP_W = $clog2(MAX_ORDER + 1);
	localparam int IDX_W = $clog2(MAX_ORDER);

	seq_state_t                     state_q;
	logic [TAP_W-1:0]               tap_q;
	logic [TAP_W-1:0]               tap_m1;
	logic [TAP_W-1:0]               n_taps;
	logic                           order_four_q;
	logic [SLOT_W-1:0]              coef_q [NUM_COEF];
	logic signed [STATE_W-1:0]      delay_q [MAX_ORDER];
	logic signed [STATE_W-1:0]      w_q;
	logic                           clip_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           saturated_q;

	logic                           accept;
	logic                           out_free;
	logic [COEF_IDX_W-1:0]          coef_idx;
	logic signed [COEF_WIDTH-1:0]   coef;
	logic signed [STATE_W-1:0]      data;
	logic signed [STATE_W-1:0]      mac_result;
	logic                           mac_clip;
	mac_ctrl_t                      mac_ctrl;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_four_q <= 1'b0;
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= (i == int'(COEF_B0)) ? B0_RESET : '0;
			end
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ORDER_FOUR: order_four_q <= cfg_data[0];
				REG_B0_B1: begin
					coef_q[COEF_B0] <= cfg_data[31:0];
					coef_q[COEF_B1] <= cfg_data[63:32];
				end
				REG_B2_B3: begin
					coef_q[COEF_B2] <= cfg_data[31:0];
					coef_q[COEF_B3] <= cfg_data[63:32];
				end
				REG_B4_A1: begin
					coef_q[COEF_B4] <= cfg_data[31:0];
					coef_q[COEF_A1] <= cfg_data[63:32];
				end
				REG_A2_A3: begin
					coef_q[COEF_A2] <= cfg_data[31:0];
					coef_q[COEF_A3] <= cfg_data[63:32];
				end
				REG_A4: coef_q[COEF_A4] <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Fourth order only exists when the build has room for four taps.
	assign n_taps = (MAX_ORDER >= 4 && order_four_q) ? TAP_W'(4) : TAP_W'(2);

	// ---------------------------------------------------------------- operand select
	assign accept   = samples.valid && samples.ready;
	assign out_free = !out_valid_q || results.ready;
	assign tap_m1   = tap_q - TAP_W'(1);

	always_comb begin
		// Feedback step k multiplies a(k+1) by tap k; feedforward step 0 multiplies b0 by
		// the new state and step k multiplies b(k) by tap k-1.
		if (state_q == ST_FBACK) begin
			coef_idx = COEF_A1 + COEF_IDX_W'(tap_q);
			data     = delay_q[tap_q[IDX_W-1:0]];
		end else begin
			coef_idx = COEF_B0 + COEF_IDX_W'(tap_q);
			data     = (tap_q == '0) ? w_q : delay_q[tap_m1[IDX_W-1:0]];
		end
		coef = coef_q[coef_idx][COEF_WIDTH-1:0];
	end

	always_comb begin
		mac_ctrl.load_sample = accept && (samples.command == CMD_FILTER);
		mac_ctrl.clear       = (state_q == ST_FB_ROUND);
		mac_ctrl.issue       = (state_q == ST_FBACK) || (state_q == ST_FFWD);
		mac_ctrl.subtract    = (state_q == ST_FBACK);
		mac_ctrl.to_sample   = (state_q == ST_FF_ROUND);
	end

	iirdf2_mac #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (samples.sample_in),
		.coef   (coef),
		.data   (data),
		.result (mac_result),
		.clip   (mac_clip)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
			clip_q  <= 1'b0;
			w_q     <= '0;
			for (int i = 0; i < MAX_ORDER; i++) begin
				delay_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (samples.command == CMD_CLEAR) begin
							for (int i = 0; i < MAX_ORDER; i++) begin
								delay_q[i] <= '0;
							end
						end else begin
							state_q <= ST_FBACK;
							tap_q   <= '0;
							clip_q  <= 1'b0;
						end
					end
				end
				ST_FBACK: begin
					if (tap_q == n_taps - TAP_W'(1)) begin
						state_q <= ST_FB_DRAIN;
					end else begin
						tap_q <= tap_q + TAP_W'(1);
					end
				end
				ST_FB_DRAIN: state_q <= ST_FB_ROUND;
				ST_FB_ROUND: begin
					w_q     <= mac_result;
					clip_q  <= mac_clip;
					tap_q   <= '0;
					state_q <= ST_FFWD;
				end
				ST_FFWD: begin
					if (tap_q == n_taps) begin
						state_q <= ST_FF_DRAIN;
					end else begin
						tap_q <= tap_q + TAP_W'(1);
					end
				end
				ST_FF_DRAIN: state_q <= ST_FF_ROUND;
				ST_FF_ROUND: begin
					// Hold here while an earlier word still waits to be taken.
					if (out_free) begin
						delay_q[0] <= w_q;
						for (int k = 1; k < MAX_ORDER; k++) begin
							if (TAP_W'(k) < n_taps) begin
								delay_q[k] <= delay_q[k-1];
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The result word is raised by the final rounding step and dropped once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FF_ROUND && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FF_ROUND && out_free) begin
			sample_out_q <= mac_result[SAMPLE_WIDTH-1:0];
			saturated_q  <= clip_q || mac_clip;
		end
	end

	assign samples.ready      = (state_q == ST_IDLE);
	assign results.valid      = out_valid_q;
	assign results.sample_out = sample_out_q;
	assign results.saturated  = saturated_q;

	// ---------------------------------------------------------------- checks
	a_result_from_round: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FF_ROUND))
		else $error("result word raised outside the final rounding step");

	a_feedback_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FBACK) |-> (tap_q < n_taps))
		else $error("feedback tap counter beyond the filter order");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.command == CMD_CLEAR) |=> (delay_q[0] == '0 && delay_q[1] == '0))
		else $error("clear command left the delay line nonzero");

endmodule
